FILE: hdl/windowed_rsi_indicator_unit_assert.svh
// Assertion macros for the windowed RSI unit.
// Uses the including scope's clk and rst_n; no other dependencies.
`ifndef WINDOWED_RSI_INDICATOR_UNIT_ASSERT_SVH
`define WINDOWED_RSI_INDICATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define WRSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define WRSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/wrsi_pkg.sv
// Shared types and constants of the windowed RSI unit.
// No dependencies.
`timescale 1ns / 1ps

package wrsi_pkg;

  localparam int unsigned VALUE_W     = 23;
  localparam int unsigned COUNT_W     = 8;
  localparam logic [VALUE_W-1:0] RSI_FULL     = 23'd6553600;  // 100.0 in 7.16
  localparam logic [COUNT_W-1:0] WINDOW_RESET = 8'd14;
  localparam int unsigned DIV_STEPS   = VALUE_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_NORMAL  = 2'd0,
    ST_NO_LOSS = 2'd1,
    ST_NO_GAIN = 2'd2,
    ST_NO_MOVE = 2'd3
  } rsi_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_ACC,
    S_CHECK,
    S_MUL,
    S_SUM,
    S_NUM,
    S_DIV,
    S_EMIT
  } wrsi_state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic acc;
    logic mul;
    logic sum;
    logic num;
    logic div_step;
    logic emit;
  } wrsi_cmd_t;

  typedef struct packed {
    logic primed;
    logic window_end;
    logic special;
    logic div_last;
    logic out_free;
  } wrsi_sts_t;

endpackage

FILE: hdl/wrsi_if.sv
// Handshake channel interfaces of the windowed RSI unit: price in, result out.
// No dependencies.
`timescale 1ns / 1ps

interface wrsi_in_if #(parameter int PRICE_BITS = 32) ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface wrsi_out_if ();
  logic        valid;
  logic        ready;
  logic [22:0] rsi_value;
  logic [1:0]  rsi_status;

  modport source (output valid, output rsi_value, output rsi_status, input ready);
  modport sink   (input valid, input rsi_value, input rsi_status, output ready);
endinterface

FILE: hdl/windowed_rsi_indicator_unit.sv
// Windowed RSI unit: top level joining the controller and the datapath.
// Depends on wrsi_pkg, wrsi_if, wrsi_ctrl, wrsi_dp and the assertion macro header.
//
// Usage:
//   in_ch carries one closing price per transfer. The first price after reset
//   only primes the previous price; each later price yields one difference.
//   After window_length differences (cfg_wr_en/cfg_wr_data, reset value 14,
//   zero acts as one) out_ch delivers one RSI in 7.16 with a status code.
//   Sequencing: a price that does not close a window holds the input through
//   transfer, difference, accumulate and window check. A closing price then
//   passes the ratio terms (multiply, sum, numerator) and a restoring divider
//   retiring one quotient bit a cycle over 23 bits before the result is
//   registered. Windows with no losses or no gains skip the divider.
//   The result register parts the channels: new prices are taken while a
//   result waits; only a second window end stalls until out_ch frees up.
//   Reset (rst_n low, synchronous) clears the window, the primed flag and any
//   pending result, and restores window_length to 14.
//   Write configuration only while the unit is idle.
`timescale 1ns / 1ps

`include "windowed_rsi_indicator_unit_assert.svh"

module windowed_rsi_indicator_unit
  import wrsi_pkg::*;
#(
  parameter int PRICE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  wrsi_in_if.sink           in_ch,
  wrsi_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  wrsi_cmd_t cmd;
  wrsi_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  wrsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wrsi_dp #(
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_price       (in_ch.price),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_rsi_value  (out_ch.rsi_value),
    .out_rsi_status (out_ch.rsi_status)
  );

  `WRSI_ASSERT_IMP(a_emit_needs_free, cmd.emit, sts.out_free && !in_ready, "result overwritten")
  `WRSI_ASSERT_NXT(a_emit_sets_valid, cmd.emit, out_ch.valid, "result not valid after load")
  `WRSI_ASSERT_NXT(a_div_ends, cmd.div_step && sts.div_last, !cmd.div_step, "divider overran")
  `WRSI_ASSERT_IMP(a_ready_no_work, in_ready, !cmd.diff && !cmd.acc && !cmd.div_step, "not idle")

endmodule

FILE: hdl/wrsi_ctrl.sv
// Sequencing state machine of the windowed RSI unit.
// Depends on wrsi_pkg for the state, command and status types.
`timescale 1ns / 1ps

module wrsi_ctrl
  import wrsi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  wrsi_sts_t sts,
  output wrsi_cmd_t cmd
);

  wrsi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        // first price only primes the previous-price register
        if (in_valid) state_nxt = sts.primed ? S_DIFF : S_IDLE;
      end
      S_DIFF:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_CHECK;
      S_CHECK: begin
        priority if (!sts.window_end) state_nxt = S_IDLE;
        else if (sts.special)         state_nxt = S_EMIT;
        else                          state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_NUM;
      S_NUM:   state_nxt = S_DIV;
      S_DIV:   if (sts.div_last) state_nxt = S_EMIT;
      S_EMIT:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIFF:  cmd.diff     = 1'b1;
      S_ACC:   cmd.acc      = 1'b1;
      S_CHECK: ;
      S_MUL:   cmd.mul      = 1'b1;
      S_SUM:   cmd.sum      = 1'b1;
      S_NUM:   cmd.num      = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_EMIT:  cmd.emit     = sts.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hdl/wrsi_dp.sv
// Datapath of the windowed RSI unit: window sums, ratio terms, divider, result register.
// Depends on wrsi_pkg for the command and status types and the constants.
`timescale 1ns / 1ps

module wrsi_dp
  import wrsi_pkg::*;
#(
  parameter int PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wrsi_cmd_t             cmd,
  output wrsi_sts_t             sts,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [VALUE_W-1:0]    out_rsi_value,
  output logic [1:0]            out_rsi_status
);

  localparam int SUM_W  = PRICE_BITS + 8;
  localparam int PROD_W = SUM_W + COUNT_W;
  localparam int D_W    = PROD_W + 1;
  localparam int A100_W = PROD_W + 7;
  localparam int DS_W   = D_W + VALUE_W - 1;
  localparam int N_W    = A100_W + 17;

  logic [COUNT_W-1:0]    window_len_r;
  logic [PRICE_BITS-1:0] price_r, prev_r, mag_r;
  logic                  primed_r, up_r, dn_r;
  logic [SUM_W-1:0]      gain_sum_r, loss_sum_r;
  logic [COUNT_W-1:0]    gain_cnt_r, loss_cnt_r, diff_cnt_r;
  logic [PROD_W-1:0]     a_r, b_r;
  logic [D_W-1:0]        d_r;
  logic [A100_W-1:0]     a100_r;
  logic [N_W-1:0]        rem_r;
  logic [DS_W-1:0]       ds_r;
  logic [VALUE_W-1:0]    q_r;
  logic [STEP_W-1:0]     step_r;
  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_value_r;
  rsi_status_t           out_status_r;

  logic [COUNT_W-1:0]    limit;
  logic                  rem_ge;
  logic [VALUE_W-1:0]    res_value;
  rsi_status_t           res_status;

  assign limit  = (window_len_r == '0) ? COUNT_W'(1) : window_len_r;
  assign rem_ge = rem_r >= N_W'(ds_r);

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_RESET;
      primed_r     <= 1'b0;
      prev_r       <= '0;
      gain_sum_r   <= '0;
      loss_sum_r   <= '0;
      gain_cnt_r   <= '0;
      loss_cnt_r   <= '0;
      diff_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) window_len_r <= cfg_wr_data;
      if (cmd.load && !primed_r) begin
        prev_r   <= in_price;
        primed_r <= 1'b1;
      end
      if (cmd.diff) prev_r <= price_r;
      if (cmd.acc) begin
        diff_cnt_r <= diff_cnt_r + COUNT_W'(1);
        if (up_r) begin
          gain_sum_r <= gain_sum_r + SUM_W'(mag_r);
          gain_cnt_r <= gain_cnt_r + COUNT_W'(1);
        end else if (dn_r) begin
          loss_sum_r <= loss_sum_r + SUM_W'(mag_r);
          loss_cnt_r <= loss_cnt_r + COUNT_W'(1);
        end
      end
      if (cmd.emit) begin
        gain_sum_r  <= '0;
        loss_sum_r  <= '0;
        gain_cnt_r  <= '0;
        loss_cnt_r  <= '0;
        diff_cnt_r  <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load && primed_r) price_r <= in_price;
    if (cmd.diff) begin
      up_r  <= price_r > prev_r;
      dn_r  <= price_r < prev_r;
      mag_r <= (price_r > prev_r) ? price_r - prev_r : prev_r - price_r;
    end
    if (cmd.mul) begin
      a_r <= PROD_W'(gain_sum_r) * PROD_W'(loss_cnt_r);
      b_r <= PROD_W'(loss_sum_r) * PROD_W'(gain_cnt_r);
    end
    if (cmd.sum) begin
      d_r    <= D_W'(a_r) + D_W'(b_r);
      // times 100 as 64 + 32 + 4
      a100_r <= (A100_W'(a_r) << 6) + (A100_W'(a_r) << 5) + (A100_W'(a_r) << 2);
    end
    if (cmd.num) begin
      // scale to 7.16 and add half the divisor to round
      rem_r  <= (N_W'(a100_r) << 16) + N_W'(d_r >> 1);
      ds_r   <= DS_W'(d_r) << (VALUE_W - 1);
      q_r    <= '0;
      step_r <= STEP_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      if (rem_ge) rem_r <= rem_r - N_W'(ds_r);
      q_r    <= {q_r[VALUE_W-2:0], rem_ge};
      ds_r   <= ds_r >> 1;
      step_r <= step_r - STEP_W'(1);
    end
    if (cmd.emit) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  always_comb begin
    priority if (gain_sum_r == '0 && loss_sum_r == '0) begin
      res_value  = '0;
      res_status = ST_NO_MOVE;
    end else if (loss_sum_r == '0) begin
      res_value  = RSI_FULL;
      res_status = ST_NO_LOSS;
    end else if (gain_sum_r == '0) begin
      res_value  = '0;
      res_status = ST_NO_GAIN;
    end else begin
      res_value  = (q_r > RSI_FULL) ? RSI_FULL : q_r;
      res_status = ST_NORMAL;
    end
  end

  assign sts.primed     = primed_r;
  assign sts.window_end = diff_cnt_r >= limit;
  assign sts.special    = (gain_sum_r == '0) || (loss_sum_r == '0);
  assign sts.div_last   = step_r == '0;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_rsi_value  = out_value_r;
  assign out_rsi_status = out_status_r;

endmodule
